/* rtl/hcw_pkg.sv */
package hcw_pkg;

  // default palette size limit
  localparam int MAX_COLORS_DFLT = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HUE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = CFG_IDX_W'(4);

  // field widths
  localparam int COUNT_REG_W = 7;
  localparam int HUE_W       = 15;
  localparam int LEVEL_W     = 11;
  localparam int ALPHA_W     = 8;
  localparam int COLOR_W     = 32;
  localparam int IDX_W       = 6;

  // hue in 1/64 degree, full turn and one-unit level in Q1.10
  localparam logic [HUE_W-1:0]   FULL_TURN = 15'd23040;
  localparam logic [LEVEL_W-1:0] ONE_Q10   = 11'd1024;

  // step divider bit counter
  localparam int DIV_CNT_W = $clog2(HUE_W);

  // job queue depth between front and back
  localparam int JOB_Q_DEPTH = 2;

  // one palette job, already clamped and reduced
  typedef struct packed {
    logic [HUE_W-1:0]   hue_start;
    logic [HUE_W-1:0]   step;
    logic [LEVEL_W-1:0] saturation;
    logic [LEVEL_W-1:0] lightness;
    logic [ALPHA_W-1:0] alpha;
  } job_t;

endpackage

/* rtl/hsl_color_wheel_generator_unit.sv */
// Channel   Signals                                  Transfer when
// --------  ---------------------------------------  ---------------------
// in        in_valid, in_ready, start_req            in_valid & in_ready
// out       out_valid, out_ready, color/index/last   out_valid & out_ready
// config    wr_en, wr_index, wr_data                 wr_en (no wait)
//
// A start transfer keeps in_ready low while the divider runs its 15 steps for
// the hue step and until the push into the 2-entry job queue; the back pops a
// job once idle with its pipeline empty, passes through the B_CHROMA, B_LEVEL
// and B_SCALE setup states, then emits one color per cycle while out_ready
// allows, through 3 stages. Division overlaps emission of the previous job.
// rst (synchronous) restores defaults, empties the queue; low out_ready stalls.
module hsl_color_wheel_generator_unit #(
  parameter int MAX_COLORS = hcw_pkg::MAX_COLORS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           wr_en,
  input  logic [hcw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [hcw_pkg::CFG_DATA_W-1:0] wr_data,
  // start requests
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           start_req,
  // palette colors
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hcw_pkg::COLOR_W-1:0]    color,
  output logic [hcw_pkg::IDX_W-1:0]      index,
  output logic                           last
);
  import hcw_pkg::*;

  // count must hold MAX_COLORS itself
  localparam int CNT_W = $clog2(MAX_COLORS + 1);
  localparam int JOB_W = $bits(job_t) + CNT_W;

  // front -> queue
  logic             push_valid;
  logic             push_ready;
  job_t             push_job;
  logic [CNT_W-1:0] push_count;

  // queue -> back
  logic             pop_valid;
  logic             pop_ready;
  logic [JOB_W-1:0] pop_data;
  job_t             pop_job;
  logic [CNT_W-1:0] pop_count;

  // front: config registers, request filtering, clamping and step divide
  hcw_front #(
    .MAX_COLORS (MAX_COLORS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_req  (start_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .push_count (push_count)
  );

  // short job queue decoupling the divider from color emission
  hcw_job_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (JOB_Q_DEPTH)
  ) u_job_q (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_job, push_count}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_job   = pop_data[JOB_W-1:CNT_W];
  assign pop_count = pop_data[CNT_W-1:0];

  // back: per-palette chroma/offset setup, then hue walk and color pipeline
  hcw_back #(
    .MAX_COLORS (MAX_COLORS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .pop_count (pop_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color     (color),
    .index     (index),
    .last      (last)
  );

endmodule

/* rtl/hcw_front.sv */
module hcw_front #(
  parameter int MAX_COLORS = hcw_pkg::MAX_COLORS_DFLT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [hcw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [hcw_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         start_req,
  output logic                         push_valid,
  input  logic                         push_ready,
  output hcw_pkg::job_t                push_job,
  output logic [$clog2(MAX_COLORS+1)-1:0] push_count
);
  import hcw_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLORS + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state;

  // configuration registers
  logic [COUNT_REG_W-1:0] reg_count;
  logic [HUE_W-1:0]       reg_base;
  logic [LEVEL_W-1:0]     reg_sat;
  logic [LEVEL_W-1:0]     reg_light;
  logic [ALPHA_W-1:0]     reg_alpha;

  // latched job
  logic [CNT_W-1:0]   count;
  logic [HUE_W-1:0]   base;
  logic [LEVEL_W-1:0] sat;
  logic [LEVEL_W-1:0] light;
  logic [ALPHA_W-1:0] alpha;

  // restoring divider for the hue step
  logic [CNT_W-1:0]     div_rem;
  logic [HUE_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0] div_bit;
  logic [CNT_W:0]       rem_sh;
  logic                 rem_ge;

  logic             accept;
  logic [CNT_W-1:0] count_sat;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (32'(reg_count) > 32'(MAX_COLORS)) begin
      count_sat = CNT_W'(MAX_COLORS);
    end else begin
      count_sat = CNT_W'(reg_count);
    end
  end

  assign rem_sh = {div_rem, FULL_TURN[div_bit]};
  assign rem_ge = (rem_sh >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= COUNT_REG_W'(1);
      reg_base  <= '0;
      reg_sat   <= ONE_Q10;
      reg_light <= LEVEL_W'(512);
      reg_alpha <= '1;
    end else if (wr_en) begin
      case (wr_index)
        REG_COLOR_COUNT: reg_count <= wr_data[COUNT_REG_W-1:0];
        REG_BASE_HUE:    reg_base  <= wr_data[HUE_W-1:0];
        REG_SATURATION:  reg_sat   <= wr_data[LEVEL_W-1:0];
        REG_LIGHTNESS:   reg_light <= wr_data[LEVEL_W-1:0];
        REG_ALPHA:       reg_alpha <= wr_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          // zero requests and empty palettes are dropped here
          if (accept && start_req && (reg_count != '0)) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_bit == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count   <= count_sat;
      base    <= (reg_base >= FULL_TURN) ? reg_base - FULL_TURN : reg_base;
      sat     <= (reg_sat > ONE_Q10) ? ONE_Q10 : reg_sat;
      light   <= (reg_light > ONE_Q10) ? ONE_Q10 : reg_light;
      alpha   <= reg_alpha;
      div_rem <= '0;
      div_quo <= '0;
      div_bit <= DIV_CNT_W'(HUE_W - 1);
    end else if (state == F_DIV) begin
      div_rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, count}) : CNT_W'(rem_sh);
      div_quo <= {div_quo[HUE_W-2:0], rem_ge};
      div_bit <= div_bit - DIV_CNT_W'(1);
    end
  end

  assign push_valid          = (state == F_PUSH);
  assign push_count          = count;
  assign push_job.hue_start  = base;
  assign push_job.step       = div_quo;
  assign push_job.saturation = sat;
  assign push_job.lightness  = light;
  assign push_job.alpha      = alpha;

endmodule

/* rtl/hcw_job_fifo.sv */
module hcw_job_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = hcw_pkg::JOB_Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import hcw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/hcw_back.sv */
module hcw_back #(
  parameter int MAX_COLORS = hcw_pkg::MAX_COLORS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  hcw_pkg::job_t                   pop_job,
  input  logic [$clog2(MAX_COLORS+1)-1:0] pop_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hcw_pkg::COLOR_W-1:0]     color,
  output logic [hcw_pkg::IDX_W-1:0]       index,
  output logic                            last
);
  import hcw_pkg::*;

  localparam int CNT_W    = $clog2(MAX_COLORS + 1);
  localparam int CHROMA_W = 21;   // up to 2^20
  localparam int LVL_W    = 22;   // 2048 * lightness, up to 2^21
  localparam int SCL_W    = 30;   // 255 * level
  localparam int G_W      = 12;   // position within a sector, 0..3840
  localparam int PROD_W   = 32;

  localparam logic [G_W-1:0] SECTOR_SPAN = 12'd3840;

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_CHROMA = 5'b00010,
    B_LEVEL  = 5'b00100,
    B_SCALE  = 5'b01000,
    B_RUN    = 5'b10000
  } back_state_t;

  // 60 degree sectors of the wheel
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  back_state_t state;
  job_t        job;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] pos;
  logic [HUE_W-1:0] hue;

  // per-job terms
  logic [CHROMA_W-1:0] chroma;
  logic [LVL_W-1:0]    mval;     // 2048*L - C
  logic [LVL_W-1:0]    csum;     // 2048*L + C
  logic [SCL_W-1:0]    m255;
  logic [7:0]          byte_c;
  logic [7:0]          byte_0;

  // pipeline
  logic             s0_valid;
  sector_t          s0_sector;
  logic [G_W-1:0]   s0_g;
  logic [IDX_W-1:0] s0_index;
  logic             s0_last;
  logic              s1_valid;
  sector_t           s1_sector;
  logic [PROD_W-1:0] s1_prod;
  logic [IDX_W-1:0]  s1_index;
  logic              s1_last;

  logic en;
  logic issue;

  // setup terms
  logic [LEVEL_W:0]   two_l;
  logic [LEVEL_W:0]   lvl_dev;
  logic [LEVEL_W-1:0] span;
  logic [LVL_W-1:0]   lx;

  // hue decomposition
  sector_t          sect;
  logic [HUE_W-1:0] sect_base;
  logic [G_W-1:0]   frac;
  logic [G_W-1:0]   g_val;
  logic [HUE_W:0]   hue_sum;
  logic [HUE_W-1:0] hue_next;

  // secondary channel
  logic [PROD_W+4:0] x17;
  logic [SCL_W-1:0]  xsum;
  logic [7:0]        byte_x;
  logic [7:0]        red;
  logic [7:0]        grn;
  logic [7:0]        blu;

  assign en        = !out_valid || out_ready;
  assign issue     = (state == B_RUN) && en;
  assign pop_ready = (state == B_IDLE) && !s0_valid && !s1_valid;

  assign two_l   = {job.lightness, 1'b0};
  assign lvl_dev = (two_l >= (LEVEL_W + 1)'(ONE_Q10)) ? two_l - (LEVEL_W + 1)'(ONE_Q10)
                                                      : (LEVEL_W + 1)'(ONE_Q10) - two_l;
  assign span    = LEVEL_W'((LEVEL_W + 1)'(ONE_Q10) - lvl_dev);
  assign lx      = {job.lightness, 11'b0};

  always_comb begin
    if (hue >= 15'd19200) begin
      sect = SEC_MAG_RED;
      sect_base = 15'd19200;
    end else if (hue >= 15'd15360) begin
      sect = SEC_BLU_MAG;
      sect_base = 15'd15360;
    end else if (hue >= 15'd11520) begin
      sect = SEC_CYN_BLU;
      sect_base = 15'd11520;
    end else if (hue >= 15'd7680) begin
      sect = SEC_GRN_CYN;
      sect_base = 15'd7680;
    end else if (hue >= 15'd3840) begin
      sect = SEC_YEL_GRN;
      sect_base = 15'd3840;
    end else begin
      sect = SEC_RED_YEL;
      sect_base = '0;
    end
    frac  = G_W'(hue - sect_base);
    // falling edge of x in odd sectors
    g_val = sect[0] ? SECTOR_SPAN - frac : frac;
  end

  assign hue_sum  = (HUE_W + 1)'(hue) + (HUE_W + 1)'(job.step);
  assign hue_next = (hue_sum >= (HUE_W + 1)'(FULL_TURN)) ?
                    HUE_W'(hue_sum - (HUE_W + 1)'(FULL_TURN)) : HUE_W'(hue_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE:   if (pop_valid && pop_ready) state <= B_CHROMA;
        B_CHROMA: state <= B_LEVEL;
        B_LEVEL:  state <= B_SCALE;
        B_SCALE:  state <= B_RUN;
        B_RUN: begin
          if (en && (pos == cnt - CNT_W'(1))) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job <= pop_job;
      cnt <= pop_count;
    end
    if (state == B_CHROMA) begin
      chroma <= CHROMA_W'((2 * LEVEL_W)'(span) * (2 * LEVEL_W)'(job.saturation));
    end
    if (state == B_LEVEL) begin
      mval <= (lx >= LVL_W'(chroma)) ? lx - LVL_W'(chroma) : '0;
      csum <= lx + LVL_W'(chroma);
    end
    if (state == B_SCALE) begin
      m255   <= SCL_W'({mval, 8'b0}) - SCL_W'(mval);
      byte_0 <= 8'(SCL_W'(SCL_W'({mval, 8'b0}) - SCL_W'(mval)) >> 21);
      byte_c <= 8'(SCL_W'(SCL_W'({csum, 8'b0}) - SCL_W'(csum)) >> 21);
      hue    <= job.hue_start;
      pos    <= '0;
    end else if (issue) begin
      hue <= hue_next;
      pos <= pos + CNT_W'(1);
    end
  end

  // stage 0: sector split, stage 1: C*g, then the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= (state == B_RUN);
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

  assign x17    = (PROD_W + 5)'({s1_prod, 4'b0}) + (PROD_W + 5)'(s1_prod);
  assign xsum   = m255 + SCL_W'(x17 >> 7);
  assign byte_x = xsum[28:21];

  always_comb begin
    case (s1_sector)
      SEC_RED_YEL: begin red = byte_c; grn = byte_x; blu = byte_0; end
      SEC_YEL_GRN: begin red = byte_x; grn = byte_c; blu = byte_0; end
      SEC_GRN_CYN: begin red = byte_0; grn = byte_c; blu = byte_x; end
      SEC_CYN_BLU: begin red = byte_0; grn = byte_x; blu = byte_c; end
      SEC_BLU_MAG: begin red = byte_x; grn = byte_0; blu = byte_c; end
      default:     begin red = byte_c; grn = byte_0; blu = byte_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sector <= sect;
      s0_g      <= g_val;
      s0_index  <= IDX_W'(pos);
      s0_last   <= (pos == cnt - CNT_W'(1));
      s1_sector <= s0_sector;
      s1_prod   <= PROD_W'(PROD_W'(chroma) * PROD_W'(s0_g));
      s1_index  <= s0_index;
      s1_last   <= s0_last;
      color     <= {job.alpha, red, grn, blu};
      index     <= s1_index;
      last      <= s1_last;
    end
  end

endmodule
